// ===== hw/rtl/ahc_pkg.sv =====
`default_nettype none

package ahc_pkg;

   // Widths fixed by the field definitions.
   localparam int INTERVAL_BITS = 16;
   localparam logic [INTERVAL_BITS-1:0] INTERVAL_RESET = 16'd5000;

   // Default widths for the time and error-count fields.
   localparam int TIME_BITS_DEFAULT  = 48;
   localparam int COUNT_BITS_DEFAULT = 32;

   // Command codes carried by a request beat.
   localparam logic CMD_ASSESS      = 1'b0;
   localparam logic CMD_MARK_FAILED = 1'b1;

   typedef enum logic [2:0] {
      HS_UNKNOWN  = 3'd0,
      HS_FAILED   = 3'd1,
      HS_DEGRADED = 3'd2,
      HS_IDLE     = 3'd3,
      HS_HEALTHY  = 3'd4
   } health_type;

   typedef enum logic [2:0] {
      RS_UNPROVEN      = 3'd0,
      RS_FATAL         = 3'd1,
      RS_SHUTDOWN      = 3'd2,
      RS_COUNTER_RESET = 3'd3,
      RS_NEW_ERRORS    = 3'd4,
      RS_INVALID_ACT   = 3'd5,
      RS_NO_ACT        = 3'd6,
      RS_RECENT        = 3'd7
   } reason_type;

endpackage

`default_nettype wire

// ===== hw/rtl/ahc_req_if.sv =====
`default_nettype none

interface ahc_req_if #(
   parameter int TIME_BITS  = ahc_pkg::TIME_BITS_DEFAULT,
   parameter int COUNT_BITS = ahc_pkg::COUNT_BITS_DEFAULT
);
   logic                  valid;
   logic                  ready;
   logic                  cmd;
   logic [TIME_BITS-1:0]  now_ms;
   logic                  activity_valid;
   logic [TIME_BITS-1:0]  activity_ms;
   logic [COUNT_BITS-1:0] err_sum;
   logic                  final_report;

   modport source (
      output valid, cmd, now_ms, activity_valid, activity_ms, err_sum, final_report,
      input  ready
   );

   modport sink (
      input  valid, cmd, now_ms, activity_valid, activity_ms, err_sum, final_report,
      output ready
   );
endinterface

`default_nettype wire

// ===== hw/rtl/ahc_rsp_if.sv =====
`default_nettype none

interface ahc_rsp_if #(
   parameter int TIME_BITS  = ahc_pkg::TIME_BITS_DEFAULT,
   parameter int COUNT_BITS = ahc_pkg::COUNT_BITS_DEFAULT
);
   logic                   valid;
   logic                   ready;
   ahc_pkg::health_type    health_state;
   ahc_pkg::reason_type    reason_code;
   logic                   counter_was_reset;
   logic                   new_errors_valid;
   logic [COUNT_BITS-1:0]  new_error_count;
   logic                   window_valid;
   logic [TIME_BITS-1:0]   window_ms;

   modport source (
      output valid, health_state, reason_code, counter_was_reset, new_errors_valid,
             new_error_count, window_valid, window_ms,
      input  ready
   );

   modport sink (
      input  valid, health_state, reason_code, counter_was_reset, new_errors_valid,
             new_error_count, window_valid, window_ms,
      output ready
   );
endinterface

`default_nettype wire

// ===== hw/rtl/activity_health_classifier_top.sv =====
// Activity health classifier.
// Request beats arrive on req_bus. An assess beat carries the current time, an
// optional last-activity time, the running error total and a shutdown flag; it
// yields exactly one response beat on rsp_bus with the health state, reason,
// counter-reset and new-error information and the window since the last assess.
// A mark-failed beat sets a sticky failed flag and yields no response beat.
// The interval register is written through csr_we / csr_wdata; the user must
// write it only while the block is idle, as the block does not enforce this.
// The idle limit is twice the interval, recovery needs one interval. A beat
// is captured in an input register, then classified into the response
// register. Throughput: one beat per cycle while the receiver keeps up. The
// history registers are updated as a beat leaves the input register, so the
// next beat is classified against them. When the receiver stalls, the
// response register holds its beat and the input register can still take
// one more beat; after that req_bus.ready drops. Reset clears the history,
// the recovery mark and the failed flag, empties both registers and restores
// the interval to 5000 ms.
`default_nettype none

module activity_health_classifier_top #(
   parameter int TIME_BITS  = ahc_pkg::TIME_BITS_DEFAULT,
   parameter int COUNT_BITS = ahc_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   ahc_req_if.sink                                req_bus,
   ahc_rsp_if.source                              rsp_bus,
   input  wire logic                              csr_we,
   input  wire logic [ahc_pkg::INTERVAL_BITS-1:0] csr_wdata
);

   localparam int IB = ahc_pkg::INTERVAL_BITS;

   // Interval register.
   logic [IB-1:0] interval_ff;

   // Input register: one captured request beat.
   logic                  in_valid_ff;
   logic                  in_cmd_ff;
   logic [TIME_BITS-1:0]  in_now_ff;
   logic                  in_act_valid_ff;
   logic [TIME_BITS-1:0]  in_act_ff;
   logic [COUNT_BITS-1:0] in_errs_ff;
   logic                  in_final_ff;

   // History kept between assess beats.
   logic                  prev_valid_ff, prev_valid_in;
   logic [TIME_BITS-1:0]  prev_time_ff, prev_time_in;
   logic [COUNT_BITS-1:0] prev_errs_ff, prev_errs_in;
   logic                  rec_valid_ff, rec_valid_in;
   logic [TIME_BITS-1:0]  rec_time_ff, rec_time_in;
   logic                  failed_ff, failed_in;

   // Response register.
   logic                  out_valid_ff;
   ahc_pkg::health_type   out_state_ff, out_state_in;
   ahc_pkg::reason_type   out_reason_ff, out_reason_in;
   logic                  out_reset_ff, out_reset_in;
   logic [COUNT_BITS-1:0] out_count_ff, out_count_in;
   logic                  out_win_valid_ff;
   logic [TIME_BITS-1:0]  out_win_ff, out_win_in;

   logic                  advance;
   logic                  is_assess;
   logic                  new_nz;
   logic                  rec_mark;
   logic                  rec_valid_mid;
   logic [TIME_BITS-1:0]  rec_time_mid;
   logic [TIME_BITS-1:0]  act_age;
   logic [TIME_BITS-1:0]  rec_age;
   logic [TIME_BITS-1:0]  limit;

   // The input register moves on when the response slot is free or draining.
   // A mark-failed beat produces nothing and always moves on.
   assign is_assess = (in_cmd_ff == ahc_pkg::CMD_ASSESS);
   assign advance   = in_valid_ff && (!is_assess || !out_valid_ff || rsp_bus.ready);

   assign req_bus.ready = !in_valid_ff || advance;

   assign limit   = TIME_BITS'({interval_ff, 1'b0});
   assign act_age = in_now_ff - in_act_ff;

   always_comb begin
      out_reset_in  = prev_valid_ff && (in_errs_ff < prev_errs_ff);
      out_win_in    = prev_valid_ff ? (in_now_ff - prev_time_ff) : '0;
      out_count_in  = out_reset_in ? '0 : (in_errs_ff - prev_errs_ff);
      new_nz        = (out_count_in != '0);
      rec_mark      = out_reset_in || new_nz;
      rec_valid_mid = rec_valid_ff || rec_mark;
      rec_time_mid  = rec_mark ? in_now_ff : rec_time_ff;
      rec_age       = in_now_ff - rec_time_mid;

      out_state_in  = ahc_pkg::HS_UNKNOWN;
      out_reason_in = ahc_pkg::RS_UNPROVEN;
      rec_valid_in  = rec_valid_mid;
      rec_time_in   = rec_time_mid;

      // Fixed priority from a sticky failure down to proven recovery.
      if (failed_ff) begin
         out_state_in  = ahc_pkg::HS_FAILED;
         out_reason_in = ahc_pkg::RS_FATAL;
      end else if (in_final_ff) begin
         out_reason_in = ahc_pkg::RS_SHUTDOWN;
      end else if (out_reset_in) begin
         out_reason_in = ahc_pkg::RS_COUNTER_RESET;
      end else if (new_nz) begin
         out_state_in  = ahc_pkg::HS_DEGRADED;
         out_reason_in = ahc_pkg::RS_NEW_ERRORS;
      end else if (in_act_valid_ff && (in_act_ff > in_now_ff)) begin
         out_reason_in = ahc_pkg::RS_INVALID_ACT;
      end else if (!in_act_valid_ff || (act_age > limit)) begin
         out_state_in  = ahc_pkg::HS_IDLE;
         out_reason_in = ahc_pkg::RS_NO_ACT;
      end else if (!rec_valid_mid || ((in_act_ff > rec_time_mid) &&
                   (rec_age >= TIME_BITS'(interval_ff)))) begin
         out_state_in  = ahc_pkg::HS_HEALTHY;
         out_reason_in = ahc_pkg::RS_RECENT;
         rec_valid_in  = 1'b0;
         rec_time_in   = '0;
      end

      prev_valid_in = 1'b1;
      prev_time_in  = in_now_ff;
      prev_errs_in  = in_errs_ff;
      failed_in     = 1'b1;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff   <= ahc_pkg::INTERVAL_RESET;
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         prev_valid_ff <= 1'b0;
         prev_time_ff  <= '0;
         prev_errs_ff  <= '0;
         rec_valid_ff  <= 1'b0;
         rec_time_ff   <= '0;
         failed_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            interval_ff <= csr_wdata;
         end
         if (req_bus.valid && req_bus.ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance && is_assess) begin
            out_valid_ff  <= 1'b1;
            prev_valid_ff <= prev_valid_in;
            prev_time_ff  <= prev_time_in;
            prev_errs_ff  <= prev_errs_in;
            rec_valid_ff  <= rec_valid_in;
            rec_time_ff   <= rec_time_in;
         end else if (rsp_bus.ready) begin
            out_valid_ff  <= 1'b0;
         end
         if (advance && !is_assess) begin
            failed_ff <= failed_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_cmd_ff       <= req_bus.cmd;
         in_now_ff       <= req_bus.now_ms;
         in_act_valid_ff <= req_bus.activity_valid;
         in_act_ff       <= req_bus.activity_ms;
         in_errs_ff      <= req_bus.err_sum;
         in_final_ff     <= req_bus.final_report;
      end
      if (advance && is_assess) begin
         out_state_ff     <= out_state_in;
         out_reason_ff    <= out_reason_in;
         out_reset_ff     <= out_reset_in;
         out_count_ff     <= out_count_in;
         out_win_valid_ff <= prev_valid_ff;
         out_win_ff       <= out_win_in;
      end
   end

   assign rsp_bus.valid             = out_valid_ff;
   assign rsp_bus.health_state      = out_state_ff;
   assign rsp_bus.reason_code       = out_reason_ff;
   assign rsp_bus.counter_was_reset = out_reset_ff;
   assign rsp_bus.new_errors_valid  = !out_reset_ff;
   assign rsp_bus.new_error_count   = out_count_ff;
   assign rsp_bus.window_valid      = out_win_valid_ff;
   assign rsp_bus.window_ms         = out_win_ff;

endmodule

`default_nettype wire

// ===== tb/activity_health_classifier_checker.sv =====
`timescale 1ns / 1ps

module activity_health_classifier_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   ahc_req_if                                     req_mon,
   ahc_rsp_if                                     rsp_mon,
   input  wire logic                              csr_we,
   input  wire logic [ahc_pkg::INTERVAL_BITS-1:0] csr_wdata,
   output int                                     mismatch_count,
   output int                                     pending_count,
   output int                                     response_count
);
   import ahc_pkg::*;

   localparam int TB_T = TIME_BITS_DEFAULT;
   localparam int TB_C = COUNT_BITS_DEFAULT;

   typedef struct {
      health_type      health_state;
      reason_type      reason_code;
      logic            counter_was_reset;
      logic            new_errors_valid;
      logic [TB_C-1:0] new_error_count;
      logic            window_valid;
      logic [TB_T-1:0] window_ms;
   } verdict_type;

   // Shadow copy of the block's history and configuration.
   logic                     hist_valid;
   logic [TB_T-1:0]          hist_time;
   logic [TB_C-1:0]          hist_errors;
   logic                     recov_valid;
   logic [TB_T-1:0]          recov_time;
   logic                     failed_latched;
   logic [INTERVAL_BITS-1:0] interval_ms;

   verdict_type expected_verdicts[$];
   verdict_type want;
   int          mismatches = 0;
   int          responses  = 0;

   function automatic int field_differs(input string name, input logic [63:0] exp_val,
                                        input logic [63:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
         return 1;
      end
      return 0;
   endfunction

   task automatic classify_assess(input logic [TB_T-1:0] now, input logic act_ok,
                                  input logic [TB_T-1:0] act, input logic [TB_C-1:0] errs,
                                  input logic fin);
      verdict_type            v;
      logic                   fell;
      logic [TB_C-1:0]        delta_err;
      logic [TB_T-1:0]        since_act;
      logic [TB_T-1:0]        since_recov;
      logic [INTERVAL_BITS:0] idle_limit;
      begin
         v.health_state = HS_UNKNOWN;
         v.reason_code  = RS_UNPROVEN;
         fell           = hist_valid && (errs < hist_errors);
         delta_err      = fell ? '0 : errs - hist_errors;
         v.window_valid = hist_valid;
         v.window_ms    = hist_valid ? now - hist_time : '0;
         v.counter_was_reset = fell;
         v.new_errors_valid  = !fell;
         v.new_error_count   = delta_err;
         if (fell || delta_err != '0) begin
            recov_valid = 1'b1;
            recov_time  = now;
         end
         hist_errors = errs;
         hist_time   = now;
         hist_valid  = 1'b1;
         since_act   = now - act;
         since_recov = now - recov_time;
         idle_limit  = {interval_ms, 1'b0};
         if (failed_latched) begin
            v.health_state = HS_FAILED;
            v.reason_code  = RS_FATAL;
         end else if (fin) begin
            v.reason_code = RS_SHUTDOWN;
         end else if (fell) begin
            v.reason_code = RS_COUNTER_RESET;
         end else if (delta_err != '0) begin
            v.health_state = HS_DEGRADED;
            v.reason_code  = RS_NEW_ERRORS;
         end else if (act_ok && act > now) begin
            v.reason_code = RS_INVALID_ACT;
         end else if (!act_ok || since_act > TB_T'(idle_limit)) begin
            v.health_state = HS_IDLE;
            v.reason_code  = RS_NO_ACT;
         end else if (!recov_valid ||
                      (act > recov_time && since_recov >= TB_T'(interval_ms))) begin
            v.health_state = HS_HEALTHY;
            v.reason_code  = RS_RECENT;
            recov_valid    = 1'b0;
            recov_time     = '0;
         end
         expected_verdicts.push_back(v);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         hist_valid     = 1'b0;
         hist_time      = '0;
         hist_errors    = '0;
         recov_valid    = 1'b0;
         recov_time     = '0;
         failed_latched = 1'b0;
         interval_ms    = INTERVAL_RESET;
         expected_verdicts.delete();
      end else begin
         // Responses leave before the beat accepted at this edge can be classified.
         if (rsp_mon.valid && rsp_mon.ready) begin
            responses++;
            if (expected_verdicts.size() == 0) begin
               $display("%0t: unexpected response beat, expected none, actual state %0d reason %0d",
                        $time, rsp_mon.health_state, rsp_mon.reason_code);
               mismatches++;
            end else begin
               want = expected_verdicts.pop_front();
               mismatches += field_differs("health_state", 64'(want.health_state),
                                           64'(rsp_mon.health_state));
               mismatches += field_differs("reason_code", 64'(want.reason_code),
                                           64'(rsp_mon.reason_code));
               mismatches += field_differs("counter_was_reset", 64'(want.counter_was_reset),
                                           64'(rsp_mon.counter_was_reset));
               mismatches += field_differs("new_errors_valid", 64'(want.new_errors_valid),
                                           64'(rsp_mon.new_errors_valid));
               mismatches += field_differs("new_error_count", 64'(want.new_error_count),
                                           64'(rsp_mon.new_error_count));
               mismatches += field_differs("window_valid", 64'(want.window_valid),
                                           64'(rsp_mon.window_valid));
               mismatches += field_differs("window_ms", 64'(want.window_ms),
                                           64'(rsp_mon.window_ms));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.cmd == CMD_MARK_FAILED) begin
               failed_latched = 1'b1;
            end else begin
               classify_assess(req_mon.now_ms, req_mon.activity_valid, req_mon.activity_ms,
                               req_mon.err_sum, req_mon.final_report);
            end
         end
         if (csr_we) begin
            interval_ms = csr_wdata;
         end
      end
      mismatch_count <= mismatches;
      pending_count  <= expected_verdicts.size();
      response_count <= responses;
   end

endmodule

// ===== tb/activity_health_classifier_top_tb.sv =====
`timescale 1ns / 1ps

module activity_health_classifier_top_tb;
   import ahc_pkg::*;

   localparam int TB_T = TIME_BITS_DEFAULT;
   localparam int TB_C = COUNT_BITS_DEFAULT;

   // This leaves a wide margin over the slowest correct run before the run is
   // declared hung.
   localparam int unsigned LIMIT_CYCLES = 300000;

   // Number of random beats in each interval phase after the first one.
   localparam int PHASE_BEATS = 230;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     csr_we;
   logic [INTERVAL_BITS-1:0] csr_wdata;

   ahc_req_if req_bus ();
   ahc_rsp_if rsp_bus ();

   int mismatch_count;
   int pending_count;
   int response_count;

   // Stimulus bookkeeping. Only the main stimulus process writes these; the
   // response side reads phase_no and idle_on to shape its own stalls.
   int                       phase_no = 0;
   bit                       idle_on  = 1'b1;
   int                       beats_sent = 0;
   int                       fail_marks = 0;
   logic [INTERVAL_BITS-1:0] cur_interval;
   logic [INTERVAL_BITS-1:0] interval_plan [1:6];
   logic [TB_T-1:0]          gen_now;
   logic [TB_C-1:0]          gen_errs;

   // Response side state.
   int  rsp_stall;
   bit  long_hold_done = 1'b0;

   int unsigned cycle_count = 0;

   activity_health_classifier_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   activity_health_classifier_checker verdict_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .response_count (response_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: a run that is still going far past any correct duration has hung.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles with %0d responses outstanding.",
                  cycle_count, pending_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic logic [TB_T-1:0] random_time();
      logic [63:0] bits;
      bits = {$urandom(), $urandom()};
      return bits[TB_T-1:0];
   endfunction

   // Offers one request beat. The gap before it is drawn per beat; the beat is
   // presented at a falling edge and held until a rising edge sees ready high.
   // Valid is only lowered when a gap is taken, so back-to-back beats keep it up.
   task automatic send_beat(input logic cmd, input logic [TB_T-1:0] now,
                            input logic act_ok, input logic [TB_T-1:0] act,
                            input logic [TB_C-1:0] errs, input logic fin);
      int gap;
      begin
         gap = idle_on ? $urandom_range(0, 5) : 0;
         @(negedge clock);
         if (gap > 0) begin
            req_bus.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_bus.cmd            = cmd;
         req_bus.now_ms         = now;
         req_bus.activity_valid = act_ok;
         req_bus.activity_ms    = act;
         req_bus.err_sum        = errs;
         req_bus.final_report   = fin;
         req_bus.valid          = 1'b1;
         do @(posedge clock); while (!req_bus.ready);
         beats_sent++;
         if (cmd == CMD_MARK_FAILED) begin
            fail_marks++;
         end
      end
   endtask

   task automatic send_assess(input logic [TB_T-1:0] now, input logic act_ok,
                              input logic [TB_T-1:0] act, input logic [TB_C-1:0] errs,
                              input logic fin);
      send_beat(CMD_ASSESS, now, act_ok, act, errs, fin);
   endtask

   // Builds one random beat. Most beats follow a plausible timeline: time moves
   // forward by a fraction of the interval, activity is recent and the error
   // total rarely changes, so that recovery can actually be proven. The rest
   // are jumps, backward steps, wrap-around times, stale or future activity,
   // counter drops and arbitrary totals.
   task automatic send_random_sample(input bit mix_failed);
      int unsigned     span;
      int unsigned     pick;
      logic            cmd;
      logic            act_ok;
      logic [TB_T-1:0] act;
      logic            fin;
      begin
         span = (cur_interval == 0) ? 3 : cur_interval;
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            gen_now += $urandom_range(0, span);
         end else if (pick < 75) begin
            gen_now += $urandom_range(span, 3 * span);
         end else if (pick < 85) begin
            gen_now += $urandom_range(0, 3);
         end else if (pick < 91) begin
            gen_now += $urandom();
         end else if (pick < 95) begin
            gen_now -= $urandom_range(0, span);
         end else if (pick < 98) begin
            gen_now = random_time();
         end else begin
            gen_now = {TB_T{1'b1}} - $urandom_range(0, span);
         end

         pick = $urandom_range(0, 99);
         act_ok = 1'b1;
         if (pick < 75) begin
            act = gen_now - $urandom_range(0, 2 * span + 1);
         end else if (pick < 83) begin
            act = gen_now - (2 * span + $urandom_range(1, 3 * span));
         end else if (pick < 90) begin
            act = gen_now + $urandom_range(1, span);
         end else if (pick < 95) begin
            act_ok = 1'b0;
            act    = random_time();
         end else begin
            act = random_time();
         end

         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            gen_errs = gen_errs;
         end else if (pick < 92) begin
            gen_errs += $urandom_range(1, 5);
         end else if (pick < 96) begin
            gen_errs = (gen_errs != 0) ? $urandom_range(0, gen_errs - 1) : $urandom();
         end else begin
            gen_errs = $urandom();
         end

         fin = ($urandom_range(0, 99) < 4);
         cmd = (mix_failed && $urandom_range(0, 99) < 20) ? CMD_MARK_FAILED : CMD_ASSESS;
         send_beat(cmd, gen_now, act_ok, act, gen_errs, fin);
      end
   endtask

   // Lets the block run dry and then writes a new interval. A mark-failed beat
   // produces no response, so after the last response it also waits out anything
   // still in the two pipeline registers.
   task automatic drain_and_configure(input logic [INTERVAL_BITS-1:0] value);
      begin
         @(negedge clock);
         req_bus.valid = 1'b0;
         while (pending_count != 0) @(negedge clock);
         repeat (4) @(negedge clock);
         csr_wdata    = value;
         csr_we       = 1'b1;
         cur_interval = value;
         @(negedge clock);
         csr_we = 1'b0;
      end
   endtask

   // Response side. Before each response beat it draws a random stall, none in
   // the phases without idling. Once, in the second interval phase, it holds
   // ready low for a long stretch so that the block fills both of its registers
   // and has to push back on the request side.
   initial begin
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         rsp_stall = idle_on ? $urandom_range(0, 5) : 0;
         if (phase_no == 2 && !long_hold_done) begin
            rsp_stall      = 80;
            long_hold_done = 1'b1;
         end
         if (rsp_stall > 0) begin
            rsp_bus.ready = 1'b0;
            repeat (rsp_stall) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         @(negedge clock);
      end
   end

   initial begin
      reset                  = 1'b1;
      csr_we                 = 1'b0;
      csr_wdata              = '0;
      req_bus.valid          = 1'b0;
      req_bus.cmd            = CMD_ASSESS;
      req_bus.now_ms         = '0;
      req_bus.activity_valid = 1'b0;
      req_bus.activity_ms    = '0;
      req_bus.err_sum        = '0;
      req_bus.final_report   = 1'b0;
      cur_interval           = INTERVAL_RESET;
      gen_now                = '0;
      gen_errs               = '0;

      interval_plan[1] = 16'd100;
      interval_plan[2] = 16'd60000;
      interval_plan[3] = 16'd0;
      interval_plan[4] = 16'hFFFF;
      interval_plan[5] = 16'd1;
      interval_plan[6] = 16'($urandom_range(100, 60000));

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed beats at the reset interval of 5000 ms.
      // The first sample has no history: its whole total counts as new errors.
      send_assess(48'd1000, 1'b1, 48'd900, 32'd7, 1'b0);
      // Recent activity, but less than one interval since the errors.
      send_assess(48'd2000, 1'b1, 48'd1900, 32'd7, 1'b0);
      // One full interval after the errors with newer activity: healthy.
      send_assess(48'd6500, 1'b1, 48'd6400, 32'd7, 1'b0);
      // Activity stamped after the current time.
      send_assess(48'd7000, 1'b1, 48'd7500, 32'd7, 1'b0);
      // Activity flag clear, so the all-ones activity time is ignored.
      send_assess(48'd8000, 1'b0, {TB_T{1'b1}}, 32'd7, 1'b0);
      // Activity older than twice the interval, then exactly at that limit.
      send_assess(48'd20000, 1'b1, 48'd9000, 32'd7, 1'b0);
      send_assess(48'd21000, 1'b1, 48'd11000, 32'd7, 1'b0);
      // The error total falls: counter reset.
      send_assess(48'd22000, 1'b1, 48'd21900, 32'd3, 1'b0);
      // Shutdown assessment with nothing else going on.
      send_assess(48'd23000, 1'b1, 48'd22900, 32'd3, 1'b1);
      // Largest total, then a drop back to zero.
      send_assess(48'd24000, 1'b1, 48'd23900, {TB_C{1'b1}}, 1'b0);
      send_assess(48'd25000, 1'b1, 48'd24900, 32'd0, 1'b0);
      // Times at the top of the range and across the wrap to zero.
      send_assess({TB_T{1'b1}}, 1'b1, {TB_T{1'b1}} - 48'd255, 32'd0, 1'b0);
      send_assess(48'd5, 1'b1, {TB_T{1'b1}} - 48'd15, 32'd0, 1'b0);
      send_assess(48'd0, 1'b1, 48'd0, 32'd0, 1'b0);
      send_assess(48'h8000_0000_0000, 1'b1, 48'h8000_0000_0000 - 48'd10000, 32'd0, 1'b0);
      // Recovery edges: just short of one interval, activity equal to the
      // recovery start, and then both conditions just met.
      send_assess(48'd100000, 1'b1, 48'd99990, 32'd1, 1'b0);
      send_assess(48'd104999, 1'b1, 48'd100001, 32'd1, 1'b0);
      send_assess(48'd105000, 1'b1, 48'd100000, 32'd1, 1'b0);
      send_assess(48'd105000, 1'b1, 48'd100001, 32'd1, 1'b0);
      // Shutdown wins over new errors and over a counter reset.
      send_assess(48'd106000, 1'b1, 48'd105900, 32'd2, 1'b1);
      send_assess(48'd107000, 1'b1, 48'd106900, 32'd0, 1'b1);
      send_assess(48'd107500, 1'b0, 48'd0, 32'd0, 1'b0);

      gen_now  = 48'd107500;
      gen_errs = 32'd0;
      repeat (200) send_random_sample(1'b0);

      // One phase per interval setting. Every third phase runs with no idling
      // on either side, and the second one carries the long response stall.
      for (int p = 1; p <= 6; p++) begin
         drain_and_configure(interval_plan[p]);
         phase_no = p;
         idle_on  = (p % 3 != 1);
         repeat (PHASE_BEATS) send_random_sample(1'b0);
      end

      // The failed flag is sticky until reset, so it is raised only at the very
      // end. The first mark-failed beat carries random fields that must be
      // ignored; afterwards every assessment reports a fatal failure, whatever
      // the shutdown flag or the error total say.
      drain_and_configure(16'd5000);
      phase_no = 7;
      idle_on  = 1'b1;
      send_beat(CMD_MARK_FAILED, random_time(), 1'b1, random_time(), $urandom(), 1'b1);
      send_assess(gen_now + 48'd10, 1'b1, gen_now, gen_errs, 1'b1);
      send_assess(gen_now + 48'd20, 1'b1, gen_now, gen_errs + 32'd3, 1'b0);
      send_assess(gen_now + 48'd30, 1'b1, gen_now, 32'd0, 1'b0);
      gen_errs = 32'd0;
      repeat (30) send_random_sample(1'b1);

      // Wait for the last responses, then give the pipeline time to show any
      // response beat that should not be there.
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (8) @(negedge clock);

      $display("Sent %0d request beats (%0d mark-failed) over 7 interval settings,",
               beats_sent, fail_marks);
      $display("including 0, 1, 100, 60000 and 65535 ms; %0d response beats checked.",
               response_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
